### src/page_frame_allocator_macros.svh
// assertion macros for the page frame allocator
`ifndef PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define PFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define PFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/pfa_pkg.sv
// types, codes and constants shared by the page frame allocator
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

   localparam int PAGE_CAPACITY_DEF = 16384;
   localparam int CFG_W   = 15;
   localparam int IDX_W   = 14;
   localparam int REF_W   = 16;
   localparam int CNT_W   = 15;

   localparam logic [REF_W-1:0] REF_MAX = 16'hffff;
   localparam int LIM_CLS1 = 1 << 8;
   localparam int LIM_CLS2 = 1 << 12;

   typedef enum logic [2:0] {
      FUNC_ALLOC_ONE  = 3'd0,
      FUNC_ALLOC_CONT = 3'd1,
      FUNC_ALLOC_ALGN = 3'd2,
      FUNC_FREE       = 3'd3,
      FUNC_PIN        = 3'd4,
      FUNC_ADD        = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_SPACE  = 3'd1,
      ST_BAD_FREE  = 3'd2,
      ST_BAD_PIN   = 3'd3,
      ST_BAD_COUNT = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CLS_NONE = 2'd0,
      CLS_256  = 2'd1,
      CLS_4K   = 2'd2,
      CLS_1M   = 2'd3
   } class_type;

   typedef enum logic [0:0] {
      CSR_MAX_PAGE   = 1'b0,
      CSR_START_HINT = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_ALIGN,
      S_CAND,
      S_READ,
      S_CHECK,
      S_CLAIM,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]       func;
      logic [IDX_W-1:0] page_index;
      logic [CNT_W-1:0] page_count;
      logic [1:0]       limit_class;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [IDX_W-1:0] result_page;
      logic [REF_W-1:0] ref_after;
      logic [CNT_W-1:0] free_pages;
      logic [CNT_W-1:0] allocated_pages;
   } rsp_type;

   // one word per page: free bit and reference count
   typedef struct packed {
      logic             free;
      logic [REF_W-1:0] refs;
   } entry_type;

endpackage

`default_nettype wire

### src/pfa_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module pfa_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

### src/page_frame_allocator.sv
// page frame allocator top level: command sequencer over the page ram
//
//   port group   dir   handshake            payload
//   req_*        in    req_valid/req_stall  req_type (func, page, count, class)
//   rsp_*        out   rsp_valid/rsp_stall  rsp_type (status, page, counters)
//   csr_*        in    csr_we               csr_index, csr_wdata
//
// one item is worked at a time; each page looked at passes through S_READ (ram read)
// and then S_CHECK. a claimed run then writes its pages in turn in S_CLAIM;
// aligned allocation first steps to its start page in count-sized adds, one per
// cycle, and passes through S_CAND for each candidate start.
// free, pin and add pass through S_START, S_READ, S_CHECK and S_DONE.
// after reset a clearing pass writes every ram entry with req_stall high; csr
// writes are taken during it.
// a finished result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "page_frame_allocator_macros.svh"

module page_frame_allocator
   import pfa_pkg::*;
#(
   parameter int PAGE_CAPACITY = PAGE_CAPACITY_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   localparam int AW = $clog2(PAGE_CAPACITY);
   localparam int PW = (AW + 2 > 18) ? AW + 2 : 18;
   localparam logic [PW-1:0] CAP = PW'(PAGE_CAPACITY);
   localparam logic [AW-1:0] LAST_ROW = AW'(PAGE_CAPACITY - 1);

   state_type        state_ff, state_in;
   func_type         func_ff, func_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       cls_ff, cls_in;
   logic [PW-1:0]    emax_ff, emax_in;
   logic [PW-1:0]    lim_ff, lim_in;
   logic [PW-1:0]    ptr_ff, ptr_in;
   logic [PW-1:0]    steps_ff, steps_in;
   logic [PW-1:0]    run_ff, run_in;
   logic [PW-1:0]    cand_ff, cand_in;
   logic [PW-1:0]    off_ff, off_in;
   logic [PW-1:0]    start_ff, start_in;
   logic             pass_ff, pass_in;
   logic [PW-1:0]    found_ff, found_in;
   logic [PW-1:0]    left_ff, left_in;
   status_type       status_ff, status_in;
   logic [REF_W-1:0] refa_ff, refa_in;
   logic [CNT_W-1:0] free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0] alloc_cnt_ff, alloc_cnt_in;
   logic [CFG_W-1:0] hint_ff, hint_in;
   logic [CFG_W-1:0] max_page_ff;
   logic [AW-1:0]    clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   entry_type        ram_wdata;
   entry_type        ram_rdata;

   logic             req_take;
   logic [PW-1:0]    emax_now;
   logic [PW-1:0]    lim_now;
   logic [PW-1:0]    cnt_w;
   logic [PW-1:0]    hint_w;
   logic [PW-1:0]    idx_w;
   logic             avail;
   logic [PW-1:0]    run_next;

   pfa_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (PAGE_CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ptr_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign emax_now = (PW'(max_page_ff) < CAP) ? PW'(max_page_ff) : CAP;
   assign cnt_w    = PW'(cnt_ff);
   assign hint_w   = PW'(hint_ff);
   assign idx_w    = PW'(idx_ff);
   // read data belongs to ptr_ff, which holds still between read and check
   assign avail    = (ptr_ff < emax_ff) && ram_rdata.free;
   assign run_next = avail ? run_ff + PW'(1) : '0;

   // class 1M never bites: emax is at most a 15-bit value
   always_comb begin
      case (class_type'(cls_ff))
         CLS_256: lim_now = (emax_ff < PW'(LIM_CLS1)) ? emax_ff : PW'(LIM_CLS1);
         CLS_4K:  lim_now = (emax_ff < PW'(LIM_CLS2)) ? emax_ff : PW'(LIM_CLS2);
         default: lim_now = emax_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      cls_in       = cls_ff;
      emax_in      = emax_ff;
      lim_in       = lim_ff;
      ptr_in       = ptr_ff;
      steps_in     = steps_ff;
      run_in       = run_ff;
      cand_in      = cand_ff;
      off_in       = off_ff;
      start_in     = start_ff;
      pass_in      = pass_ff;
      found_in     = found_ff;
      left_in      = left_ff;
      status_in    = status_ff;
      refa_in      = refa_ff;
      free_cnt_in  = free_cnt_ff;
      alloc_cnt_in = alloc_cnt_ff;
      hint_in      = hint_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = ptr_ff[AW-1:0];
      ram_wdata    = '0;

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == LAST_ROW) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_take) begin
               func_in  = func_type'(req_data.func);
               idx_in   = req_data.page_index;
               cnt_in   = req_data.page_count;
               cls_in   = req_data.limit_class;
               emax_in  = emax_now;
               state_in = S_START;
            end
         end

         S_START: begin
            status_in = ST_OK;
            found_in  = '0;
            refa_in   = '0;
            lim_in    = lim_now;
            state_in  = S_DONE;
            case (func_ff)
               FUNC_ALLOC_ONE: begin
                  cnt_in   = CNT_W'(1);
                  ptr_in   = (hint_w < lim_now) ? hint_w : '0;
                  steps_in = lim_now;
                  if (lim_now == '0) begin
                     status_in = ST_NO_SPACE;
                  end else begin
                     state_in = S_READ;
                  end
               end
               FUNC_ALLOC_CONT: begin
                  ptr_in = PW'(1);
                  run_in = '0;
                  if (cnt_ff == '0) begin
                     status_in = ST_BAD_COUNT;
                  end else if (cnt_w > lim_now || lim_now <= PW'(1)) begin
                     status_in = ST_NO_SPACE;
                  end else begin
                     state_in = S_READ;
                  end
               end
               FUNC_ALLOC_ALGN: begin
                  cand_in = '0;
                  if (cnt_ff == '0) begin
                     status_in = ST_BAD_COUNT;
                  end else if (cnt_w > emax_ff) begin
                     status_in = ST_NO_SPACE;
                  end else begin
                     state_in = S_ALIGN;
                  end
               end
               FUNC_FREE, FUNC_PIN, FUNC_ADD: begin
                  ptr_in   = idx_w;
                  state_in = S_READ;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // round the hint up to a multiple of the count
         S_ALIGN: begin
            if (cand_ff >= hint_w) begin
               start_in = cand_ff;
               pass_in  = 1'b0;
               state_in = S_CAND;
            end else begin
               cand_in = cand_ff + cnt_w;
            end
         end

         S_CAND: begin
            off_in = '0;
            if (!pass_ff && (cand_ff + cnt_w > emax_ff)) begin
               pass_in = 1'b1;
               cand_in = cnt_w;
            end else if (pass_ff && cand_ff >= start_ff) begin
               status_in = ST_NO_SPACE;
               state_in  = S_DONE;
            end else if (cand_ff == '0) begin
               cand_in = cand_ff + cnt_w;
            end else begin
               ptr_in   = cand_ff;
               state_in = S_READ;
            end
         end

         S_READ: begin
            state_in = S_CHECK;
         end

         S_CHECK: begin
            state_in = S_DONE;
            case (func_ff)
               FUNC_ALLOC_ONE: begin
                  if (ptr_ff != '0 && avail) begin
                     found_in = ptr_ff;
                     left_in  = PW'(1);
                     state_in = S_CLAIM;
                  end else if (steps_ff == PW'(1)) begin
                     status_in = ST_NO_SPACE;
                  end else begin
                     steps_in = steps_ff - PW'(1);
                     ptr_in   = (ptr_ff + PW'(1) == lim_ff) ? '0 : ptr_ff + PW'(1);
                     state_in = S_READ;
                  end
               end
               FUNC_ALLOC_CONT: begin
                  run_in = run_next;
                  if (run_next == cnt_w) begin
                     found_in = ptr_ff + PW'(1) - cnt_w;
                     ptr_in   = ptr_ff + PW'(1) - cnt_w;
                     left_in  = cnt_w;
                     state_in = S_CLAIM;
                  end else if (ptr_ff + PW'(1) >= lim_ff) begin
                     status_in = ST_NO_SPACE;
                  end else begin
                     ptr_in   = ptr_ff + PW'(1);
                     state_in = S_READ;
                  end
               end
               FUNC_ALLOC_ALGN: begin
                  if (avail && off_ff + PW'(1) == cnt_w) begin
                     found_in = cand_ff;
                     ptr_in   = cand_ff;
                     left_in  = cnt_w;
                     state_in = S_CLAIM;
                  end else if (avail) begin
                     off_in   = off_ff + PW'(1);
                     ptr_in   = ptr_ff + PW'(1);
                     state_in = S_READ;
                  end else begin
                     cand_in  = cand_ff + cnt_w;
                     state_in = S_CAND;
                  end
               end
               FUNC_FREE: begin
                  if (idx_ff == '0 || idx_w >= emax_ff || ram_rdata.refs == '0) begin
                     status_in = ST_BAD_FREE;
                  end else begin
                     ram_we         = 1'b1;
                     ram_wdata.refs = ram_rdata.refs - REF_W'(1);
                     ram_wdata.free = ram_rdata.free;
                     refa_in        = ram_rdata.refs - REF_W'(1);
                     if (ram_rdata.refs == REF_W'(1)) begin
                        ram_wdata.free = 1'b1;
                        free_cnt_in    = free_cnt_ff + CNT_W'(1);
                        alloc_cnt_in   = alloc_cnt_ff - CNT_W'(1);
                        if (idx_w < hint_w) begin
                           hint_in = CFG_W'(idx_ff);
                        end
                     end
                  end
               end
               FUNC_PIN: begin
                  if (idx_w >= emax_ff || ram_rdata.refs == '0 ||
                      ram_rdata.refs == REF_MAX) begin
                     status_in = ST_BAD_PIN;
                  end else begin
                     ram_we         = 1'b1;
                     ram_wdata.free = ram_rdata.free;
                     ram_wdata.refs = ram_rdata.refs + REF_W'(1);
                     refa_in        = ram_rdata.refs + REF_W'(1);
                  end
               end
               FUNC_ADD: begin
                  // rejected adds still answer ok
                  if (idx_ff != '0 && idx_w < emax_ff && !ram_rdata.free &&
                      ram_rdata.refs == '0) begin
                     ram_we         = 1'b1;
                     ram_wdata.free = 1'b1;
                     ram_wdata.refs = '0;
                     free_cnt_in    = free_cnt_ff + CNT_W'(1);
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // one page per cycle: clear free bit, reference count one
         S_CLAIM: begin
            ram_we         = 1'b1;
            ram_wdata.free = 1'b0;
            ram_wdata.refs = REF_W'(1);
            ptr_in         = ptr_ff + PW'(1);
            left_in        = left_ff - PW'(1);
            if (left_ff == PW'(1)) begin
               free_cnt_in  = free_cnt_ff - cnt_ff;
               alloc_cnt_in = alloc_cnt_ff + cnt_ff;
               hint_in      = CFG_W'(found_ff + cnt_w);
               state_in     = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.status          = status_ff;
               rsp_data_in.result_page     = found_ff[IDX_W-1:0];
               rsp_data_in.ref_after       = refa_ff;
               rsp_data_in.free_pages      = free_cnt_ff;
               rsp_data_in.allocated_pages = alloc_cnt_ff;
               state_in                    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // csr writes are to come only while idle; the block itself does not enforce it
      if (csr_we && csr_idx_type'(csr_index) == CSR_START_HINT) begin
         hint_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         free_cnt_ff  <= '0;
         alloc_cnt_ff <= '0;
         hint_ff      <= CFG_W'(1);
         max_page_ff  <= CFG_W'(PAGE_CAPACITY_DEF);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         free_cnt_ff  <= free_cnt_in;
         alloc_cnt_ff <= alloc_cnt_in;
         hint_ff      <= hint_in;
         if (csr_we && csr_idx_type'(csr_index) == CSR_MAX_PAGE) begin
            max_page_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      cls_ff      <= cls_in;
      emax_ff     <= emax_in;
      lim_ff      <= lim_in;
      ptr_ff      <= ptr_in;
      steps_ff    <= steps_in;
      run_ff      <= run_in;
      cand_ff     <= cand_in;
      off_ff      <= off_in;
      start_ff    <= start_in;
      pass_ff     <= pass_in;
      found_ff    <= found_in;
      left_ff     <= left_in;
      status_ff   <= status_in;
      refa_ff     <= refa_in;
      rsp_data_ff <= rsp_data_in;
   end

   `PFA_ASSERT_NEXT(a_take_starts, clock, reset, req_take, state_ff == S_START, "item not started")
   `PFA_ASSERT_NOW(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE), "result without done")
   `PFA_ASSERT_NOW(a_claim_writes, clock, reset, state_ff == S_CLAIM, ram_we && !ram_wdata.free, "claim without write")

endmodule

`default_nettype wire

### test/tb_top.sv
// testbench for the page frame allocator: random and directed commands against a predictor
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
   import pfa_pkg::*;

   localparam int NPAGES = PAGE_CAPACITY_DEF;
   localparam int WATCH_LIMIT = 400000;

   class page_scoreboard;
      bit               free_map [NPAGES];
      logic [REF_W-1:0] refs [NPAGES];
      int unsigned      hint, free_cnt, alloc_cnt, max_page;
      rsp_type          want_q [$];
      int unsigned      taken [$];   // pages handed out, used to aim frees and pins
      int               errors;

      function void clear();
         foreach (free_map[i]) begin
            free_map[i] = 0;
            refs[i] = '0;
         end
         hint = 1;
         free_cnt = 0;
         alloc_cnt = 0;
         max_page = NPAGES;
         errors = 0;
      endfunction

      function void configure(csr_idx_type r, int unsigned v);
         if (r == CSR_MAX_PAGE) max_page = v & 16'h7fff;
         else hint = v & 16'h7fff;
      endfunction

      function int unsigned top_page();
         return max_page < NPAGES ? max_page : NPAGES;
      endfunction

      function bit usable(int unsigned p);
         return p < top_page() && free_map[p];
      endfunction

      function int unsigned cap_for(logic [1:0] cls);
         int unsigned lim, cap;
         lim = top_page();
         case (cls)
            CLS_256: cap = LIM_CLS1;
            CLS_4K:  cap = LIM_CLS2;
            CLS_1M:  cap = 1 << 20;
            default: cap = lim;
         endcase
         return lim < cap ? lim : cap;
      endfunction

      function void grab(int unsigned first, int unsigned n);
         for (int unsigned p = first; p < first + n; p++) begin
            free_map[p] = 0;
            refs[p] = REF_W'(1);
            taken.push_back(p);
         end
         free_cnt -= n;
         alloc_cnt += n;
         hint = (first + n) & 16'h7fff;
      endfunction

      function void note(req_type q);
         rsp_type r;
         int unsigned lim, emax, cnt, idx, found, run, first, b, e, st;
         emax = top_page();
         cnt = q.page_count;
         idx = q.page_index;
         found = 0;
         r = '0;
         r.status = ST_OK;
         case (q.func)
            FUNC_ALLOC_ONE: begin
               lim = cap_for(q.limit_class);
               first = hint < lim ? hint : 0;
               for (int ps = 0; ps < 2 && found == 0; ps++) begin
                  b = ps ? 0 : first;
                  e = ps ? first : lim;
                  for (int unsigned p = b; p < e; p++)
                     if (p != 0 && usable(p)) begin
                        found = p;
                        break;
                     end
               end
               if (found != 0) begin
                  grab(found, 1);
                  r.result_page = IDX_W'(found);
               end else r.status = ST_NO_SPACE;
            end
            FUNC_ALLOC_CONT: begin
               lim = cap_for(q.limit_class);
               if (cnt == 0) r.status = ST_BAD_COUNT;
               else if (cnt > lim) r.status = ST_NO_SPACE;
               else begin
                  run = 0;
                  for (int unsigned p = 1; p < lim; p++) begin
                     run = usable(p) ? run + 1 : 0;
                     if (run == cnt) begin
                        found = p + 1 - cnt;
                        break;
                     end
                  end
                  if (found != 0) begin
                     grab(found, cnt);
                     r.result_page = IDX_W'(found);
                  end else r.status = ST_NO_SPACE;
               end
            end
            FUNC_ALLOC_ALGN: begin
               if (cnt == 0) r.status = ST_BAD_COUNT;
               else if (cnt > emax) r.status = ST_NO_SPACE;
               else begin
                  st = ((hint + cnt - 1) / cnt) * cnt;
                  for (int ps = 0; ps < 2 && found == 0; ps++) begin
                     b = ps ? cnt : st;
                     e = ps ? st : emax - cnt + 1;
                     for (int unsigned f = b; f < e; f += cnt) begin
                        bit ok;
                        ok = (f != 0);
                        for (int unsigned i = 0; i < cnt && ok; i++)
                           if (!usable(f + i)) ok = 0;
                        if (ok) begin
                           found = f;
                           break;
                        end
                     end
                  end
                  if (found != 0) begin
                     grab(found, cnt);
                     r.result_page = IDX_W'(found);
                  end else r.status = ST_NO_SPACE;
               end
            end
            FUNC_FREE: begin
               if (idx == 0 || idx >= emax || refs[idx] == 0) r.status = ST_BAD_FREE;
               else begin
                  refs[idx] = refs[idx] - REF_W'(1);
                  r.ref_after = refs[idx];
                  if (refs[idx] == 0) begin
                     free_map[idx] = 1;
                     free_cnt++;
                     alloc_cnt--;
                     if (idx < hint) hint = idx;
                  end
               end
            end
            FUNC_PIN: begin
               if (idx >= emax || refs[idx] == 0 || refs[idx] == REF_MAX)
                  r.status = ST_BAD_PIN;
               else begin
                  refs[idx] = refs[idx] + REF_W'(1);
                  r.ref_after = refs[idx];
               end
            end
            FUNC_ADD: begin
               if (idx != 0 && idx < emax && !free_map[idx] && refs[idx] == 0) begin
                  free_map[idx] = 1;
                  free_cnt++;
               end
            end
            default: ;
         endcase
         r.free_pages = CNT_W'(free_cnt);
         r.allocated_pages = CNT_W'(alloc_cnt);
         want_q.push_back(r);
      endfunction

      function void check(rsp_type a);
         rsp_type w;
         if (want_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", a);
            return;
         end
         w = want_q.pop_front();
         if (a.status !== w.status || a.result_page !== w.result_page ||
             a.ref_after !== w.ref_after || a.free_pages !== w.free_pages ||
             a.allocated_pages !== w.allocated_pages) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: exp st %0d pg %0d ref %0d free %0d alloc %0d,",
                         " got st %0d pg %0d ref %0d free %0d alloc %0d"},
                  w.status, w.result_page, w.ref_after, w.free_pages, w.allocated_pages,
                  a.status, a.result_page, a.ref_after, a.free_pages, a.allocated_pages);
         end
      endfunction
   endclass

   logic             clock, reset;
   logic             req_valid, req_stall, rsp_valid, rsp_stall;
   req_type          req_data;
   rsp_type          rsp_data;
   logic             csr_we, csr_index;
   logic [CFG_W-1:0] csr_wdata;
   int               idle_mode;   // 0 sender light receiver heavy, 1 swapped, 2 none
   int               quiet_cycles;
   page_scoreboard   sb;

   page_frame_allocator i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      if (idle_mode == 0) rsp_stall <= ($urandom_range(99) < 63);
      else if (idle_mode == 1) rsp_stall <= ($urandom_range(99) < 27);
      else rsp_stall <= 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_data);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCH_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_reg(csr_idx_type r, int unsigned v);
      @(negedge clock);
      csr_we = 1;
      csr_index = (r == CSR_START_HINT);
      csr_wdata = CFG_W'(v);
      @(negedge clock);
      csr_we = 0;
      sb.configure(r, v);
   endtask

   task automatic send(logic [2:0] f, int unsigned idx, int unsigned cnt, logic [1:0] cls);
      int unsigned gap;
      gap = idle_mode == 0 ? 27 : idle_mode == 1 ? 63 : 0;
      @(negedge clock);
      while ($urandom_range(99) < gap) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_data.func = f;
      req_data.page_index = IDX_W'(idx);
      req_data.page_count = CNT_W'(cnt);
      req_data.limit_class = cls;
      do @(posedge clock); while (req_stall);
      sb.note(req_data);
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic drain();
      while (sb.want_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic random_cmd();
      int unsigned w, top, idx, cnt;
      logic [2:0] f;
      top = sb.top_page();
      w = $urandom_range(99);
      idx = $urandom_range(top + 8, 0) & 14'h3fff;
      if ($urandom_range(9) == 0) idx = $urandom & 14'h3fff;
      if (w < 22) f = FUNC_ADD;
      else if (w < 42) f = FUNC_ALLOC_ONE;
      else if (w < 56) f = FUNC_ALLOC_CONT;
      else if (w < 66) f = FUNC_ALLOC_ALGN;
      else if (w < 84) f = FUNC_FREE;
      else if (w < 94) f = FUNC_PIN;
      else f = 3'($urandom_range(7, 6));
      if ((f == FUNC_FREE || f == FUNC_PIN) && sb.taken.size() != 0 && $urandom_range(9) < 7)
         idx = sb.taken[$urandom_range(sb.taken.size() - 1)];
      w = $urandom_range(9);
      cnt = w < 8 ? $urandom_range(6, 1) : w == 8 ? 0 : ($urandom & 15'h7fff);
      send(f, idx, cnt, 2'($urandom));
   endtask

   task automatic run_phase(int unsigned maxp, int unsigned hnt, int mode, int n, int adds);
      drain();
      write_reg(CSR_MAX_PAGE, maxp);
      write_reg(CSR_START_HINT, hnt);
      idle_mode = mode;
      // populate the map first so allocations get past the empty state
      for (int i = 0; i < adds; i++) send(FUNC_ADD, $urandom_range(maxp, 1), 0, CLS_NONE);
      for (int i = 0; i < n; i++) begin
         random_cmd();
         if (i == n / 2) drain();
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      quiet_cycles = 0;
      idle_mode = 0;
      req_valid = 0;
      req_data = '0;
      csr_we = 0;
      csr_index = 0;
      csr_wdata = '0;
      rsp_stall = 0;
      reset = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;
      write_reg(CSR_MAX_PAGE, 200);
      write_reg(CSR_START_HINT, 1);

      // directed: add edge cases, each operation, error statuses
      send(FUNC_ADD, 0, 0, CLS_NONE);
      send(FUNC_ADD, 14'h3fff, 0, CLS_NONE);
      for (int p = 1; p <= 8; p++) send(FUNC_ADD, p, 0, CLS_NONE);
      send(FUNC_ADD, 3, 0, CLS_NONE);
      send(FUNC_ALLOC_ONE, 0, 0, CLS_NONE);
      send(FUNC_ALLOC_CONT, 0, 0, CLS_NONE);
      send(FUNC_ALLOC_CONT, 0, 15'h7fff, CLS_256);
      send(FUNC_ALLOC_CONT, 0, 3, CLS_256);
      send(FUNC_ALLOC_ALGN, 0, 0, CLS_4K);
      send(FUNC_ALLOC_ALGN, 0, 15'h7fff, CLS_1M);
      send(FUNC_ALLOC_ALGN, 0, 4, CLS_1M);
      send(FUNC_FREE, 0, 0, CLS_NONE);
      send(FUNC_PIN, 0, 0, CLS_NONE);
      send(FUNC_PIN, 2, 0, CLS_NONE);
      send(FUNC_FREE, 1, 0, CLS_NONE);
      send(FUNC_FREE, 1, 0, CLS_NONE);
      send(FUNC_PIN, 14'h3fff, 0, CLS_NONE);
      send(3'd6, 14'h3fff, 15'h7fff, CLS_1M);
      send(3'd7, 0, 0, CLS_NONE);

      run_phase(200, 1, 0, 100, 60);
      run_phase(16384, 16384, 1, 30, 5);
      run_phase(1, 0, 1, 15, 2);
      run_phase(120, 37, 1, 90, 30);
      run_phase(256, 5, 2, 120, 40);
      drain();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.want_q.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
+incdir+src
src/pfa_pkg.sv
src/pfa_ram.sv
src/page_frame_allocator.sv
test/tb_top.sv
